[design/npm_pkg.sv]
`default_nettype none

package npm_pkg;

  localparam int unsigned MaxPoints = 4096;
  localparam int unsigned IdxW      = $clog2(MaxPoints);
  localparam int unsigned CountW    = IdxW + 1;
  localparam int unsigned PaddrW    = 3;

  localparam logic [21:0] NoMatchReset = 22'd1022976;
  localparam logic [12:0] NoMatchIdx   = 13'h1FFF;
  localparam logic [31:0] SignBias     = 32'h8000_0000;

  // register select taken from paddr[2]
  localparam logic RegNoMatch = 1'b0;

  typedef enum logic [1:0] {
    ACT_CLEAR = 2'd0,
    ACT_LOAD  = 2'd1,
    ACT_QUERY = 2'd2
  } action_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_ROOT,
    ST_DONE
  } state_e;

  typedef logic signed [31:0] coord_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
  } point_t;

endpackage

`default_nettype wire

[design/npm_req_if.sv]
`default_nettype none

interface npm_req_if;
  import npm_pkg::*;

  logic        valid;
  logic        ready;
  logic [1:0]  action;
  coord_t      x_position;
  coord_t      y_position;
  coord_t      z_position;

  modport source (output valid, action, x_position, y_position, z_position, input ready);
  modport sink (input valid, action, x_position, y_position, z_position, output ready);
endinterface

`default_nettype wire

[design/npm_rsp_if.sv]
`default_nettype none

interface npm_rsp_if;
  logic               valid;
  logic               ready;
  logic signed [12:0] match_index;
  logic [31:0]        match_distance;
  logic               table_overflowed;

  modport source (output valid, match_index, match_distance, table_overflowed, input ready);
  modport sink (input valid, match_index, match_distance, table_overflowed, output ready);
endinterface

`default_nettype wire

[design/npm_isqrt.sv]
`default_nettype none

module npm_isqrt (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [63:0] value_i,
  output logic        done_o,
  output logic [31:0] root_o
);
  import npm_pkg::*;

  logic        run_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [63:0] val_q;
  logic [32:0] rem_q;
  logic [31:0] root_q;

  logic [34:0] rem_sh;
  logic [34:0] trial;
  logic        take;

  // one root bit per cycle, restoring
  assign rem_sh = {rem_q, val_q[63:62]};
  assign trial  = {1'b0, root_q, 2'b01};
  assign take   = rem_sh >= trial;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q  <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        run_q <= 1'b1;
        cnt_q <= '0;
      end else if (run_q) begin
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd31) begin
          run_q  <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      val_q  <= value_i;
      rem_q  <= '0;
      root_q <= '0;
    end else if (run_q) begin
      val_q <= {val_q[61:0], 2'b00};
      if (take) begin
        rem_q  <= 33'(rem_sh - trial);
        root_q <= {root_q[30:0], 1'b1};
      end else begin
        rem_q  <= rem_sh[32:0];
        root_q <= {root_q[30:0], 1'b0};
      end
    end
  end

  assign done_o = done_q;
  assign root_o = root_q;

`ifndef SYNTHESIS
  a_done_after_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> $past(run_q))
    else $error("root finished without a run");
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i |-> !run_q)
    else $error("root restarted while running");
`endif

endmodule

`default_nettype wire

[design/nearest_point_match_3d_top.sv]
`default_nettype none

// Brute-force 3-D nearest point match. Words on req_i clear the table (action 0), append a
// reference point (action 1, dropped and flagged once 4096 points are held) or query a point
// (action 2); action 3 is ignored. Only a query gives a word on rsp_o: the index of the first
// stored point with the strictly least squared distance below the no-match distance squared,
// and the floor square root of that distance, else index -1 and the no-match distance.
// Clear and load act on the table as they are taken. A query with N stored points reads the point
// memory once per cycle for each stored point, then a five-stage distance pipeline drains and,
// when a point matched, the square root runs one bit per cycle; the result word is then loaded
// into the output register and the next word is taken in the cycle after that load. A finished
// word waits in the output register while the next word is taken. No clearing pass after reset.
module nearest_point_match_3d_top (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  npm_req_if.sink                   req_i,
  npm_rsp_if.source                 rsp_o,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [npm_pkg::PaddrW-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready
);
  import npm_pkg::*;

  state_e state_q, state_d;

  logic [21:0]       nmd_q;
  logic [43:0]       nmd_sq;
  logic [CountW-1:0] count_q;
  logic              ovf_q;
  logic [CountW-1:0] scan_q;

  point_t            ref_mem [MaxPoints];
  point_t            rd_q;
  point_t            qry_q;
  point_t            req_pt;

  logic              p1_v_q, p2_v_q, p3_v_q, p4_v_q, p5_v_q;
  logic [IdxW-1:0]   p1_idx_q, p2_idx_q, p3_idx_q, p4_idx_q, p5_idx_q;
  logic [31:0]       dx_q, dy_q, dz_q;
  logic [63:0]       sqx_q, sqy_q, sqz_q, sqz2_q;
  logic [64:0]       sxy_q;
  logic [65:0]       tot;
  logic [63:0]       dist_q;

  logic [63:0]       best_q;
  logic [IdxW-1:0]   bidx_q;
  logic              found_q;

  logic              accept;
  logic              issue;
  logic              pipe_busy;
  logic              root_start;
  logic              root_done;
  logic [31:0]       root;
  logic              out_load;
  logic              cfg_wr;

  logic              out_v_q;
  logic [12:0]       out_idx_q;
  logic [31:0]       out_dist_q;
  logic              out_ovf_q;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == RegNoMatch);
  assign prdata = (paddr[2] == RegNoMatch) ? {10'b0, nmd_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nmd_q <= NoMatchReset;
    end else if (cfg_wr) begin
      nmd_q <= pwdata[21:0];
    end
  end

  assign nmd_sq = nmd_q * nmd_q;

  assign req_pt.x = req_i.x_position ^ SignBias;
  assign req_pt.y = req_i.y_position ^ SignBias;
  assign req_pt.z = req_i.z_position ^ SignBias;

  // sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign pipe_busy = p1_v_q || p2_v_q || p3_v_q || p4_v_q || p5_v_q;

  always_comb begin
    state_d     = state_q;
    req_i.ready = 1'b0;
    issue       = 1'b0;
    root_start  = 1'b0;
    out_load    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        req_i.ready = 1'b1;
        if (req_i.valid && req_i.action == ACT_QUERY) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (scan_q < count_q) begin
          issue = 1'b1;
        end else begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy) begin
          if (found_q) begin
            root_start = 1'b1;
            state_d    = ST_ROOT;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_ROOT: begin
        if (root_done) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_v_q || rsp_o.ready) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  assign accept = req_i.valid && req_i.ready;

  // table control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
      ovf_q   <= 1'b0;
      scan_q  <= '0;
    end else begin
      if (accept) begin
        scan_q <= '0;
        unique case (req_i.action)
          ACT_CLEAR: begin
            count_q <= '0;
            ovf_q   <= 1'b0;
          end
          ACT_LOAD: begin
            if (count_q == CountW'(MaxPoints)) begin
              ovf_q <= 1'b1;
            end else begin
              count_q <= count_q + CountW'(1);
            end
          end
          default: ;
        endcase
      end else if (issue) begin
        scan_q <= scan_q + CountW'(1);
      end
    end
  end

  // point memory
  always_ff @(posedge clk_i) begin
    if (accept && req_i.action == ACT_LOAD && count_q != CountW'(MaxPoints)) begin
      ref_mem[count_q[IdxW-1:0]] <= req_pt;
    end
    if (issue) begin
      rd_q <= ref_mem[scan_q[IdxW-1:0]];
    end
  end

  // distance pipeline
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
      p3_v_q <= 1'b0;
      p4_v_q <= 1'b0;
      p5_v_q <= 1'b0;
    end else begin
      p1_v_q <= issue;
      p2_v_q <= p1_v_q;
      p3_v_q <= p2_v_q;
      p4_v_q <= p3_v_q;
      p5_v_q <= p4_v_q;
    end
  end

  assign tot = {1'b0, sxy_q} + {2'b00, sqz2_q};

  always_ff @(posedge clk_i) begin
    if (accept) begin
      qry_q <= req_pt;
    end
    p1_idx_q <= scan_q[IdxW-1:0];
    p2_idx_q <= p1_idx_q;
    p3_idx_q <= p2_idx_q;
    p4_idx_q <= p3_idx_q;
    p5_idx_q <= p4_idx_q;
    dx_q     <= (rd_q.x >= qry_q.x) ? rd_q.x - qry_q.x : qry_q.x - rd_q.x;
    dy_q     <= (rd_q.y >= qry_q.y) ? rd_q.y - qry_q.y : qry_q.y - rd_q.y;
    dz_q     <= (rd_q.z >= qry_q.z) ? rd_q.z - qry_q.z : qry_q.z - rd_q.z;
    sqx_q    <= dx_q * dx_q;
    sqy_q    <= dy_q * dy_q;
    sqz_q    <= dz_q * dz_q;
    sxy_q    <= {1'b0, sqx_q} + {1'b0, sqy_q};
    sqz2_q   <= sqz_q;
    dist_q   <= (tot[65:64] != 2'b00) ? '1 : tot[63:0];
  end

  // running minimum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else if (accept) begin
      found_q <= 1'b0;
    end else if (p5_v_q && dist_q < best_q) begin
      found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      best_q <= 64'(nmd_sq);
    end else if (p5_v_q && dist_q < best_q) begin
      best_q <= dist_q;
      bidx_q <= p5_idx_q;
    end
  end

  npm_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (root_start),
    .value_i (best_q),
    .done_o  (root_done),
    .root_o  (root)
  );

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_load) begin
      out_v_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_idx_q  <= found_q ? {1'b0, bidx_q} : NoMatchIdx;
      out_dist_q <= found_q ? root : {10'b0, nmd_q};
      out_ovf_q  <= ovf_q;
    end
  end

  assign rsp_o.valid            = out_v_q;
  assign rsp_o.match_index      = out_idx_q;
  assign rsp_o.match_distance   = out_dist_q;
  assign rsp_o.table_overflowed = out_ovf_q;

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CountW'(MaxPoints))
    else $error("point count beyond capacity");
  a_found_in_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    found_q |-> ({1'b0, bidx_q} < count_q))
    else $error("best index outside stored points");
  a_pipe_in_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    p5_v_q |-> (state_q == ST_SCAN || state_q == ST_DRAIN))
    else $error("distance pipeline active outside a query");
  a_root_in_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    root_done |-> state_q == ST_ROOT)
    else $error("square root finished outside its state");
  a_word_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(state_q == ST_DONE))
    else $error("output word loaded outside done state");
`endif

endmodule

`default_nettype wire

[test/tb_nearest_point_match_3d_top.sv]
`timescale 1ns / 1ps

module tb_nearest_point_match_3d_top;
  import npm_pkg::*;

  localparam int          StallLimit   = 20000;
  localparam int          LongHold     = 400;
  localparam int          SettleCycles = 64;
  localparam int          PhaseItems   = 22;
  localparam logic [1:0]  ActIgnored   = 2'd3;
  localparam logic [PaddrW-1:0] NoMatchAddr = '0;
  localparam coord_t      CMax = 32'sh7FFF_FFFF;
  localparam coord_t      CMin = 32'sh8000_0000;

  typedef struct packed {
    logic signed [12:0] idx;
    logic [31:0]        distance;
    logic               ovf;
  } match_t;

  typedef struct {
    logic [1:0] act;
    coord_t     x;
    coord_t     y;
    coord_t     z;
    bit         typed;
    match_t     res;
  } dir_row_t;

  localparam match_t EmptyMatch = '{NoMatchIdx, 32'(NoMatchReset), 1'b0};

  logic clk = 1'b0;
  logic rst_n;
  logic psel, penable, pwrite;
  logic [PaddrW-1:0] paddr;
  logic [31:0] pwdata, prdata;
  logic pready;

  npm_req_if req ();
  npm_rsp_if rsp ();

  nearest_point_match_3d_top u_top (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .req_i   (req),
    .rsp_o   (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #1 clk = ~clk;

  // predictor state
  coord_t      tab_x [MaxPoints];
  coord_t      tab_y [MaxPoints];
  coord_t      tab_z [MaxPoints];
  int unsigned pts;
  bit          dropped;
  logic [21:0] nm_dist;

  match_t expected_q [$];
  int     mismatches;
  int     items_sent;
  int     queries_sent;
  int     words_checked;
  int     peak_pts;
  int     idle_cycles;
  bit     snd_burst;
  bit     rsp_burst;
  bit     fast_send;
  bit     hold_rsp;

  task automatic report_mismatch(string what, longint got, longint exp);
    mismatches++;
    $display("mismatch %s: got %0d, expected %0d (t=%0t)", what, got, exp, $realtime);
  endtask

  function automatic logic [63:0] axis_sq(coord_t a, coord_t b);
    longint      d;
    logic [63:0] m;
    d = longint'(a) - longint'(b);
    if (d < 0) d = -d;
    m = d;
    return m * m;
  endfunction

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [31:0] floor_root(logic [63:0] v);
    logic [31:0] r;
    logic [31:0] t;
    r = '0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (32'd1 << b);
      if (64'(t) * 64'(t) <= v) r = t;
    end
    return r;
  endfunction

  function automatic match_t nearest_match(coord_t x, coord_t y, coord_t z);
    logic [63:0] best;
    logic [63:0] d;
    match_t      m;
    bit          found;
    best  = 64'(nm_dist) * 64'(nm_dist);
    m.idx = NoMatchIdx;
    found = 1'b0;
    for (int i = 0; i < pts; i++) begin
      d = sat_sum(sat_sum(axis_sq(tab_x[i], x), axis_sq(tab_y[i], y)), axis_sq(tab_z[i], z));
      if (d < best) begin
        best  = d;
        m.idx = 13'(i);
        found = 1'b1;
      end
    end
    m.distance = found ? floor_root(best) : 32'(nm_dist);
    m.ovf      = dropped;
    return m;
  endfunction

  function automatic void apply_to_table(logic [1:0] act, coord_t x, coord_t y, coord_t z);
    case (act)
      ACT_CLEAR: begin
        pts     = 0;
        dropped = 1'b0;
      end
      ACT_LOAD: begin
        if (pts < MaxPoints) begin
          tab_x[pts] = x;
          tab_y[pts] = y;
          tab_z[pts] = z;
          pts++;
          if (pts > peak_pts) peak_pts = pts;
        end else begin
          dropped = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic coord_t rand_coord(bit wide);
    if (wide) return coord_t'($urandom);
    return coord_t'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
  endfunction

  function automatic coord_t jitter(coord_t c);
    return c + coord_t'(int'($urandom_range(0, 32768)) - 16384);
  endfunction

  task automatic send_word(input logic [1:0] act, input coord_t x, input coord_t y,
                           input coord_t z, input bit typed = 1'b0,
                           input match_t typed_res = '0);
    int     gap;
    match_t want;
    gap = (snd_burst || fast_send) ? 0 : $urandom_range(0, 19);
    if ($urandom_range(0, 15) == 0) snd_burst = !snd_burst;
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid      <= 1'b1;
    req.action     <= act;
    req.x_position <= x;
    req.y_position <= y;
    req.z_position <= z;
    do @(posedge clk); while (!req.ready);
    if (act != ActIgnored) items_sent++;
    if (act == ACT_QUERY) begin
      queries_sent++;
      want       = typed ? typed_res : nearest_match(x, y, z);
      expected_q = {expected_q, want};
    end
    apply_to_table(act, x, y, z);
  endtask

  task automatic wait_idle();
    req.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_no_match(logic [21:0] v);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= NoMatchAddr;
    pwdata  <= 32'(v);
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    nm_dist = v;
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata !== 32'(v)) report_mismatch("no-match readback", prdata, v);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic send_query_near(bit wide);
    int k;
    if (pts > 0 && !wide) begin
      k = $urandom_range(0, pts - 1);
      send_word(ACT_QUERY, jitter(tab_x[k]), jitter(tab_y[k]), jitter(tab_z[k]));
    end else begin
      send_word(ACT_QUERY, rand_coord(wide), rand_coord(wide), rand_coord(wide));
    end
  endtask

  // result side
  initial begin
    match_t got;
    match_t exp;
    int     gap;
    rsp.ready <= 1'b0;
    @(posedge clk);
    wait (rst_n);
    forever begin
      gap = rsp_burst ? 0 : $urandom_range(0, 19);
      if ($urandom_range(0, 15) == 0) rsp_burst = !rsp_burst;
      if (hold_rsp) begin
        gap      = LongHold;
        hold_rsp = 1'b0;
      end
      if (gap > 0) begin
        rsp.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      do @(posedge clk); while (!rsp.valid);
      got = '{rsp.match_index, rsp.match_distance, rsp.table_overflowed};
      words_checked++;
      if (expected_q.size() == 0) begin
        report_mismatch("result word with nothing pending, index", got.idx, NoMatchIdx);
      end else begin
        exp = expected_q.pop_front();
        if (got.idx !== exp.idx) report_mismatch("match_index", got.idx, exp.idx);
        if (got.distance !== exp.distance)
          report_mismatch("match_distance", got.distance, exp.distance);
        if (got.ovf !== exp.ovf) report_mismatch("table_overflowed", got.ovf, exp.ovf);
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    wait (idle_cycles >= StallLimit);
    $display("tb_nearest_point_match_3d_top: done, errors");
    $finish;
  end

  // stimulus
  initial begin
    dir_row_t    dir_rows [19];
    logic [21:0] nm_plan [4];
    int          start;
    int          n;
    logic [1:0]  act;

    rst_n          <= 1'b0;
    req.valid      <= 1'b0;
    req.action     <= ACT_CLEAR;
    req.x_position <= '0;
    req.y_position <= '0;
    req.z_position <= '0;
    psel           <= 1'b0;
    penable        <= 1'b0;
    pwrite         <= 1'b0;
    paddr          <= '0;
    pwdata         <= '0;
    idle_cycles    = 0;
    mismatches     = 0;
    items_sent     = 0;
    queries_sent   = 0;
    words_checked  = 0;
    peak_pts       = 0;
    snd_burst      = 1'b0;
    rsp_burst      = 1'b0;
    fast_send      = 1'b0;
    hold_rsp       = 1'b0;
    pts            = 0;
    dropped        = 1'b0;
    nm_dist        = NoMatchReset;

    dir_rows = '{
      '{ACT_QUERY,  0,       0,    0,     1'b1, EmptyMatch},
      '{ActIgnored, CMax,    CMin, CMax,  1'b0, '0},
      '{ACT_QUERY,  CMin,    CMax, CMin,  1'b1, EmptyMatch},
      '{ACT_LOAD,   0,       0,    0,     1'b0, '0},
      '{ACT_QUERY,  0,       0,    0,     1'b1, '{13'sd0, 32'd0, 1'b0}},
      '{ACT_LOAD,   CMax,    CMax, CMax,  1'b0, '0},
      '{ACT_LOAD,   CMin,    CMin, CMin,  1'b0, '0},
      '{ACT_QUERY,  CMax,    CMax, CMax,  1'b1, '{13'sd1, 32'd0, 1'b0}},
      '{ACT_QUERY,  CMin,    CMin, CMin,  1'b1, '{13'sd2, 32'd0, 1'b0}},
      '{ACT_QUERY,  CMin,    CMax, CMin,  1'b0, '0},
      '{ACT_LOAD,   0,       0,    0,     1'b0, '0},
      '{ACT_QUERY,  0,       0,    0,     1'b1, '{13'sd0, 32'd0, 1'b0}},
      '{ACT_QUERY,  1022976, 0,    0,     1'b1, EmptyMatch},
      '{ACT_QUERY,  1022975, 0,    0,     1'b1, '{13'sd0, 32'd1022975, 1'b0}},
      '{ACT_QUERY,  -1024,   -2048, 2048, 1'b1, '{13'sd0, 32'd3072, 1'b0}},
      '{ACT_LOAD,   3000,    -4000, 0,    1'b0, '0},
      '{ACT_QUERY,  3000,    -4000, 12000, 1'b0, '0},
      '{ACT_CLEAR,  CMax,    CMax, CMax,  1'b0, '0},
      '{ACT_QUERY,  0,       0,    0,     1'b1, EmptyMatch}
    };

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i])
      send_word(dir_rows[i].act, dir_rows[i].x, dir_rows[i].y, dir_rows[i].z,
                dir_rows[i].typed, dir_rows[i].res);

    nm_plan[0] = '0;
    nm_plan[1] = 22'h3F_FFFF;
    nm_plan[2] = 22'($urandom_range(0, 32'h3F_FFFF));
    nm_plan[3] = NoMatchReset;

    for (int ph = 0; ph < 4; ph++) begin
      wait_idle();
      write_no_match(nm_plan[ph]);
      send_word(ACT_CLEAR, rand_coord(1'b1), rand_coord(1'b1), rand_coord(1'b1));
      start = items_sent;
      if (ph == 1) begin
        repeat (4) send_word(ACT_LOAD, rand_coord(1'b0), rand_coord(1'b0), rand_coord(1'b0));
        hold_rsp  = 1'b1;
        fast_send = 1'b1;
        repeat (8) send_query_near(1'b0);
        fast_send = 1'b0;
        wait_idle();
      end
      while (items_sent - start < PhaseItems) begin
        if ($urandom_range(0, 9) == 0) begin
          act = 2'($urandom_range(0, 3));
          send_word(act, rand_coord(1'b1), rand_coord(1'b1), rand_coord(1'b1));
        end else begin
          if ($urandom_range(0, 1) == 0)
            send_word(ACT_CLEAR, rand_coord(1'b1), rand_coord(1'b1), rand_coord(1'b1));
          n = ($urandom_range(0, 11) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
          repeat (n) send_word(ACT_LOAD, rand_coord($urandom_range(0, 7) == 0),
                               rand_coord(1'b0), rand_coord($urandom_range(0, 7) == 0));
          n = $urandom_range(1, 6);
          repeat (n) send_query_near($urandom_range(0, 4) == 0);
        end
      end
    end

    wait_idle();
    $display("run covered %0d input words, %0d of them queries, table filled to %0d points",
             items_sent, queries_sent, peak_pts);
    $display("%0d result words checked over 5 no-match settings, %0d mismatches",
             words_checked, mismatches);
    if (mismatches == 0) begin
      $display("tb_nearest_point_match_3d_top: done, clean");
    end else begin
      $display("tb_nearest_point_match_3d_top: done, errors");
    end
    $finish;
  end

endmodule
